/* rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Shared command codes and field widths of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	// Width of the command field carried on tuser.
	localparam int CMD_W = 3;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CONJ = 3'd4;
	localparam logic [CMD_W-1:0] CMD_MOD  = 3'd5;

	// Status bits on the result tuser, from the highest bit down.
	typedef struct packed {
		logic saturated;
		logic div_by_zero;
	} cau_flags_t;

endpackage

/* rtl/cau_div.sv */
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per register stage.
// Keeps the low quotient bits plus a sticky overflow of all higher bits,
// and carries a side payload alongside each request.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int NUM_W = 80,
	parameter int DEN_W = 64,
	parameter int Q_W   = 32,
	parameter int PL_W  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [PL_W-1:0]  in_pl,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_q,
	output logic             out_ovf,
	output logic [PL_W-1:0]  out_pl
);

	// Stage zero is the incoming request; stage k holds k quotient bits.
	logic             vld_sn [0:NUM_W];
	logic [NUM_W-1:0] num_sn [0:NUM_W];
	logic [DEN_W-1:0] den_sn [0:NUM_W];
	logic [DEN_W-1:0] rem_sn [0:NUM_W];
	logic [Q_W-1:0]   quo_sn [0:NUM_W];
	logic             ovf_sn [0:NUM_W];
	logic [PL_W-1:0]  pl_sn  [0:NUM_W];

	assign vld_sn[0] = in_valid;
	assign num_sn[0] = in_num;
	assign den_sn[0] = in_den;
	assign rem_sn[0] = '0;
	assign quo_sn[0] = '0;
	assign ovf_sn[0] = 1'b0;
	assign pl_sn[0]  = in_pl;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		// Shift in the next numerator bit and try to subtract the divisor.
		always_comb begin
			trial = {rem_sn[i], num_sn[i][NUM_W-1]};
			diff  = trial - {1'b0, den_sn[i]};
			ge    = ~diff[DEN_W];
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[i+1] <= 1'b0;
			end else if (en) begin
				vld_sn[i+1] <= vld_sn[i];
			end
		end

		// Data of this stage.
		always_ff @(posedge clk) begin
			if (en) begin
				num_sn[i+1] <= {num_sn[i][NUM_W-2:0], 1'b0};
				den_sn[i+1] <= den_sn[i];
				rem_sn[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_sn[i+1] <= {quo_sn[i][Q_W-2:0], ge};
				ovf_sn[i+1] <= ovf_sn[i] | quo_sn[i][Q_W-1];
				pl_sn[i+1]  <= pl_sn[i];
			end
		end
	end

	assign out_valid = vld_sn[NUM_W];
	assign out_q     = quo_sn[NUM_W];
	assign out_ovf   = ovf_sn[NUM_W];
	assign out_pl    = pl_sn[NUM_W];

endmodule

/* rtl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Signed fixed-point complex ALU: add, subtract, multiply, divide,
// conjugate and squared modulus, with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_axis channel: tdata packs a_real, a_imag, b_real,
// b_imag and tuser holds the command. Each request gives exactly one result
// on the m_axis channel: tdata packs result_real, result_imag and tuser holds
// div_by_zero and saturated.
// Every command passes through the divider, which resolves one quotient
// bit per register stage; all commands travel the same path so results
// leave in request order.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver holds m_axis_tready low while a result waits, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset clears every valid bit, so the block comes up empty and ready.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
	import cau_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// a_real, a_imag, b_real, b_imag, zero padding
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// command
	input  logic [CMD_W-1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// result_real, result_imag, zero padding
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// div_by_zero, saturated
	output logic [1:0] m_axis_tuser
);

	localparam int W       = DATA_WIDTH;
	localparam int PW      = 2*W;
	localparam int SW      = 2*W + 1;
	localparam int NUM_W   = 2*W + FRAC_BITS;
	localparam int PL_RE_W = SW + 3;
	localparam int PL_IM_W = SW + 1;
	localparam int OUT_DW  = ((2*W+7)/8)*8;

	localparam logic signed [SW-1:0] MAX_S = SW'((64'sd1 <<< (W-1)) - 64'sd1);
	localparam logic signed [SW-1:0] MIN_S = -SW'(64'sd1 <<< (W-1));

	logic en;
	logic out_valid_q;

	// Whole pipeline advances unless a finished result is blocked.
	assign en            = ~out_valid_q | m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: register the request.
	logic                 v_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= s_axis_tuser;
			ar_s1  <= s_axis_tdata[W-1:0];
			ai_s1  <= s_axis_tdata[2*W-1:W];
			br_s1  <= s_axis_tdata[3*W-1:2*W];
			bi_s1  <= s_axis_tdata[4*W-1:3*W];
		end
	end

	// Stage 2: all partial products.
	logic                 v_s2;
	logic [CMD_W-1:0]     cmd_s2;
	logic signed [W-1:0]  ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_bbr_s2, p_bbi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= cmd_s1;
			ar_s2    <= ar_s1;
			ai_s2    <= ai_s1;
			br_s2    <= br_s1;
			bi_s2    <= bi_s1;
			p_rr_s2  <= PW'(ar_s1 * br_s1);
			p_ii_s2  <= PW'(ai_s1 * bi_s1);
			p_ri_s2  <= PW'(ar_s1 * bi_s1);
			p_ir_s2  <= PW'(ai_s1 * br_s1);
			p_bbr_s2 <= PW'(br_s1 * br_s1);
			p_bbi_s2 <= PW'(bi_s1 * bi_s1);
		end
	end

	// Stage 3: combine according to the command.
	logic signed [SW-1:0] re_c, im_c, mod_c;
	logic signed [SW-1:0] ar_x, ai_x, br_x, bi_x;
	logic signed [SW-1:0] rr_x, ii_x, ri_x, ir_x;

	always_comb begin
		ar_x  = SW'(ar_s2);
		ai_x  = SW'(ai_s2);
		br_x  = SW'(br_s2);
		bi_x  = SW'(bi_s2);
		rr_x  = SW'(p_rr_s2);
		ii_x  = SW'(p_ii_s2);
		ri_x  = SW'(p_ri_s2);
		ir_x  = SW'(p_ir_s2);
		mod_c = SW'(p_bbr_s2) + SW'(p_bbi_s2);
		case (cmd_s2)
			CMD_ADD:  begin re_c = ar_x + br_x; im_c = ai_x + bi_x; end
			CMD_SUB:  begin re_c = ar_x - br_x; im_c = ai_x - bi_x; end
			CMD_MUL:  begin re_c = rr_x - ii_x; im_c = ri_x + ir_x; end
			CMD_DIV:  begin re_c = rr_x + ii_x; im_c = ir_x - ri_x; end
			CMD_CONJ: begin re_c = br_x; im_c = -bi_x; end
			CMD_MOD:  begin re_c = mod_c; im_c = '0; end
			default:  begin re_c = '0; im_c = '0; end
		endcase
	end

	logic                 v_s3;
	logic [CMD_W-1:0]     cmd_s3;
	logic signed [SW-1:0] re_s3, im_s3, mod_s3;
	logic signed [W-1:0]  br_s3, bi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			re_s3  <= re_c;
			im_s3  <= im_c;
			mod_s3 <= mod_c;
			br_s3  <= br_s2;
			bi_s3  <= bi_s2;
		end
	end

	// Stage 4: rescale products toward zero, or set up the division.
	logic [SW-1:0]        re_mag, im_mag;
	logic signed [SW-1:0] re_pre, im_pre;
	logic                 is_div, div_zero;

	always_comb begin
		re_mag   = re_s3[SW-1] ? SW'(-re_s3) : SW'(re_s3);
		im_mag   = im_s3[SW-1] ? SW'(-im_s3) : SW'(im_s3);
		is_div   = (cmd_s3 == CMD_DIV);
		div_zero = is_div && (mod_s3 == '0);
		re_pre   = re_s3;
		im_pre   = im_s3;
		if (cmd_s3 == CMD_MUL || cmd_s3 == CMD_MOD) begin
			re_pre = re_s3[SW-1] ? -$signed(re_mag >> FRAC_BITS)
				: $signed(re_mag >> FRAC_BITS);
			im_pre = im_s3[SW-1] ? -$signed(im_mag >> FRAC_BITS)
				: $signed(im_mag >> FRAC_BITS);
		end else if (div_zero) begin
			re_pre = SW'(br_s3);
			im_pre = SW'(bi_s3);
		end
	end

	logic                 v_s4;
	logic signed [SW-1:0] re_pre_s4, im_pre_s4;
	logic [PW-1:0]        re_num_s4, im_num_s4, den_s4;
	logic                 quo_s4, neg_re_s4, neg_im_s4, dz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_pre_s4 <= re_pre;
			im_pre_s4 <= im_pre;
			re_num_s4 <= re_mag[PW-1:0];
			im_num_s4 <= im_mag[PW-1:0];
			den_s4    <= mod_s3[PW-1:0];
			quo_s4    <= is_div && !div_zero;
			neg_re_s4 <= re_s3[SW-1];
			neg_im_s4 <= im_s3[SW-1];
			dz_s4     <= div_zero;
		end
	end

	// Dividers: each lane carries the side payload of its own result part.
	logic [NUM_W-1:0]   re_num_w, im_num_w;
	logic [PL_RE_W-1:0] pl_re_in, pl_re_out;
	logic [PL_IM_W-1:0] pl_im_in, pl_im_out;
	logic               dv_re, dv_im, ovf_re, ovf_im;
	logic [W-1:0]       q_re, q_im;

	assign re_num_w = NUM_W'(re_num_s4) << FRAC_BITS;
	assign im_num_w = NUM_W'(im_num_s4) << FRAC_BITS;
	assign pl_re_in = {re_pre_s4, quo_s4, neg_re_s4, dz_s4};
	assign pl_im_in = {im_pre_s4, neg_im_s4};

	cau_div #(.NUM_W(NUM_W), .DEN_W(PW), .Q_W(W), .PL_W(PL_RE_W)) u_div_re (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.in_num(re_num_w), .in_den(den_s4), .in_pl(pl_re_in),
		.out_valid(dv_re), .out_q(q_re), .out_ovf(ovf_re), .out_pl(pl_re_out)
	);

	cau_div #(.NUM_W(NUM_W), .DEN_W(PW), .Q_W(W), .PL_W(PL_IM_W)) u_div_im (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.in_num(im_num_w), .in_den(den_s4), .in_pl(pl_im_in),
		.out_valid(dv_im), .out_q(q_im), .out_ovf(ovf_im), .out_pl(pl_im_out)
	);

	// Final saturation of both parts.
	logic signed [SW-1:0] pre_re_d, pre_im_d;
	logic                 quo_d, neg_re_d, neg_im_d, dz_d;
	logic [W-1:0]         res_re, res_im;
	logic                 sat_re, sat_im;
	logic [W-1:0]         lim_re, lim_im;

	always_comb begin
		{pre_re_d, quo_d, neg_re_d, dz_d} = pl_re_out;
		{pre_im_d, neg_im_d}              = pl_im_out;
		lim_re = neg_re_d ? W'(MAX_S) + W'(1) : W'(MAX_S);
		lim_im = neg_im_d ? W'(MAX_S) + W'(1) : W'(MAX_S);
		if (quo_d) begin
			sat_re = ovf_re || (q_re > lim_re);
			sat_im = ovf_im || (q_im > lim_im);
			res_re = sat_re ? lim_re : q_re;
			res_im = sat_im ? lim_im : q_im;
			res_re = neg_re_d ? -res_re : res_re;
			res_im = neg_im_d ? -res_im : res_im;
		end else begin
			sat_re = (pre_re_d > MAX_S) || (pre_re_d < MIN_S);
			sat_im = (pre_im_d > MAX_S) || (pre_im_d < MIN_S);
			res_re = (pre_re_d > MAX_S) ? W'(MAX_S)
				: (pre_re_d < MIN_S) ? W'(MIN_S) : pre_re_d[W-1:0];
			res_im = (pre_im_d > MAX_S) ? W'(MAX_S)
				: (pre_im_d < MIN_S) ? W'(MIN_S) : pre_im_d[W-1:0];
		end
	end

	// Output register.
	logic [W-1:0] res_re_q, res_im_q;
	cau_flags_t   flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_re & dv_im;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q            <= res_re;
			res_im_q            <= res_im;
			flags_q.div_by_zero <= dz_d;
			flags_q.saturated   <= sat_re | sat_im;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DW'({res_im_q, res_re_q});
	assign m_axis_tuser  = {flags_q.saturated, flags_q.div_by_zero};

endmodule

/* tb/sv/cau_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cau_checker
// Watches both streams of the complex arithmetic unit, computes the expected
// result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module cau_checker
	import cau_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	// a_real, a_imag, b_real, b_imag, zero padding
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// command
	input  logic [CMD_W-1:0] s_axis_tuser,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	// result_real, result_imag, zero padding
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// div_by_zero, saturated
	input  logic [1:0] m_axis_tuser,
	output int   errors,
	output int   pending
);

	localparam int W = DATA_WIDTH;

	typedef struct packed {
		logic [W-1:0] re;
		logic [W-1:0] im;
		logic         dbz;
		logic         sat;
	} cplx_result_t;

	cplx_result_t result_q[$];

	assign pending = result_q.size();

	// Clamp an exact value to the signed data range, noting any clamp.
	function automatic logic [W-1:0] clamp(input logic signed [191:0] v, inout logic hit);
		logic signed [191:0] hi_lim, lo_lim;
		hi_lim = (192'sd1 <<< (W-1)) - 1;
		lo_lim = -(192'sd1 <<< (W-1));
		if (v > hi_lim) begin
			hit = 1'b1;
			return hi_lim[W-1:0];
		end
		if (v < lo_lim) begin
			hit = 1'b1;
			return lo_lim[W-1:0];
		end
		return v[W-1:0];
	endfunction

	// Shift right with truncation toward zero.
	function automatic logic signed [191:0] trunc_shr(input logic signed [191:0] v);
		if (v < 0)
			return -((-v) >>> FRAC_BITS);
		return v >>> FRAC_BITS;
	endfunction

	// Scaled quotient truncated toward zero; m is positive.
	function automatic logic signed [191:0] trunc_div(input logic signed [191:0] n,
		input logic signed [191:0] m);
		logic signed [191:0] mag;
		mag = ((n < 0 ? -n : n) <<< FRAC_BITS) / m;
		return n < 0 ? -mag : mag;
	endfunction

	function automatic cplx_result_t complex_result(input logic [CMD_W-1:0] cmd,
		input logic [4*W-1:0] ops);
		logic signed [191:0] ar, ai, br, bi, rr, ri, m;
		cplx_result_t r;
		ar = $signed(ops[W-1:0]);
		ai = $signed(ops[2*W-1:W]);
		br = $signed(ops[3*W-1:2*W]);
		bi = $signed(ops[4*W-1:3*W]);
		rr = 0;
		ri = 0;
		r  = '0;
		m  = br*br + bi*bi;
		case (cmd)
			CMD_ADD: begin
				rr = ar + br;
				ri = ai + bi;
			end
			CMD_SUB: begin
				rr = ar - br;
				ri = ai - bi;
			end
			CMD_MUL: begin
				rr = trunc_shr(ar*br - ai*bi);
				ri = trunc_shr(ar*bi + ai*br);
			end
			CMD_DIV: begin
				if (m == 0) begin
					rr = br;
					ri = bi;
					r.dbz = 1'b1;
				end else begin
					rr = trunc_div(ar*br + ai*bi, m);
					ri = trunc_div(ai*br - ar*bi, m);
				end
			end
			CMD_CONJ: begin
				rr = br;
				ri = -bi;
			end
			CMD_MOD: rr = trunc_shr(m);
			default: ;
		endcase
		r.re = clamp(rr, r.sat);
		r.im = clamp(ri, r.sat);
		return r;
	endfunction

	// Predict on each accepted request, compare on each accepted result.
	always @(posedge clk or negedge arst_n) begin
		cplx_result_t exp_r;
		if (!arst_n) begin
			errors = 0;
			result_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(complex_result(s_axis_tuser, s_axis_tdata[4*W-1:0]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result re=%h im=%h flags=%b", $time,
						m_axis_tdata[W-1:0], m_axis_tdata[2*W-1:W], m_axis_tuser);
				end else begin
					exp_r = result_q.pop_front();
					if (m_axis_tdata[W-1:0] !== exp_r.re) begin
						errors++;
						$display("%0t: result_real expected %h actual %h", $time,
							exp_r.re, m_axis_tdata[W-1:0]);
					end
					if (m_axis_tdata[2*W-1:W] !== exp_r.im) begin
						errors++;
						$display("%0t: result_imag expected %h actual %h", $time,
							exp_r.im, m_axis_tdata[2*W-1:W]);
					end
					if (m_axis_tuser[0] !== exp_r.dbz) begin
						errors++;
						$display("%0t: div_by_zero expected %b actual %b", $time,
							exp_r.dbz, m_axis_tuser[0]);
					end
					if (m_axis_tuser[1] !== exp_r.sat) begin
						errors++;
						$display("%0t: saturated expected %b actual %b", $time,
							exp_r.sat, m_axis_tuser[1]);
					end
				end
			end
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random complex operand requests into the arithmetic
// unit under varying source and sink stalls; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;
	import cau_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int IN_W  = ((4*DW+7)/8)*8;
	localparam int OUT_W = ((2*DW+7)/8)*8;
	localparam int LATENCY = 5 + 2*DW + FB;
	localparam logic [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] ONE_V = 1 << FB;
	localparam logic [DW-1:0] NEG1  = '1;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic [CMD_W-1:0] s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0]       m_axis_tuser;
	int               errors;
	int               pending;
	int               send_idle_pct;
	int               recv_idle_pct;

	complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (.*);

	cau_checker #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// Sink stalls at the currently chosen rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
	end

	// Operand value biased toward edge cases.
	function automatic logic [DW-1:0] pick_operand();
		case ($urandom_range(9))
			0: return MAX_V;
			1: return MIN_V;
			2: return '0;
			3: return ONE_V;
			4: return NEG1;
			5: return $urandom_range(1 << 20) - (1 << 19);
			6: return $signed($urandom_range(1 << 22) - (1 << 21)) <<< 4;
			default: return $urandom;
		endcase
	endfunction

	// Present one request, holding it until accepted; valid drops only while idling.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DW-1:0] ar,
		input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {bi, br, ai, ar};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	initial begin
		logic [CMD_W-1:0] cmd;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every command, divide by zero, conjugate of minimum.
		send_request(CMD_ADD,  MAX_V, MIN_V, MAX_V, MIN_V);
		send_request(CMD_ADD,  MIN_V, MAX_V, ONE_V, NEG1);
		send_request(CMD_SUB,  MIN_V, MAX_V, ONE_V, NEG1);
		send_request(CMD_SUB,  '0, '0, MIN_V, MIN_V);
		send_request(CMD_MUL,  ONE_V, ONE_V, ONE_V, NEG1);
		send_request(CMD_MUL,  MIN_V, MIN_V, MIN_V, MIN_V);
		send_request(CMD_MUL,  MAX_V, MIN_V, MAX_V, MAX_V);
		send_request(CMD_DIV,  ONE_V, ONE_V, '0, '0);
		send_request(CMD_DIV,  MAX_V, MIN_V, '0, '0);
		send_request(CMD_DIV,  ONE_V, '0, ONE_V, ONE_V);
		send_request(CMD_DIV,  MIN_V, MAX_V, 32'd1, '0);
		send_request(CMD_DIV,  NEG1, ONE_V, MIN_V, MAX_V);
		send_request(CMD_CONJ, '0, '0, MAX_V, MIN_V);
		send_request(CMD_CONJ, MAX_V, MAX_V, MIN_V, MAX_V);
		send_request(CMD_MOD,  '0, '0, MIN_V, MIN_V);
		send_request(CMD_MOD,  '0, '0, ONE_V, NEG1);
		send_request(3'd6,     MAX_V, MIN_V, ONE_V, NEG1);
		send_request(3'd7,     NEG1, NEG1, NEG1, NEG1);

		// Random requests in three stall phases.
		for (int i = 0; i < 2000; i++) begin
			if (i == 0) begin
				send_idle_pct = 32;
				recv_idle_pct = 58;
			end else if (i == 700) begin
				send_idle_pct = 58;
				recv_idle_pct = 32;
			end else if (i == 1400) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			cmd = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(7, 6))
				: CMD_W'($urandom_range(5));
			send_request(cmd, pick_operand(), pick_operand(), pick_operand(),
				pick_operand());
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit.sv
tb/sv/cau_checker.sv
tb/sv/testbench.sv
